### hdl/pcfd_pkg.sv
// Shared types and constants for the padded command frame decoder.
package pcfd_pkg;

  localparam int unsigned FRAME_LEN = 17;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);
  localparam logic [7:0]  PAD_BYTE  = 8'hFF;

  localparam logic [POS_W-1:0] POS_CMD      = POS_W'(4);
  localparam logic [POS_W-1:0] POS_VAL_LO   = POS_W'(9);
  localparam logic [POS_W-1:0] POS_VAL_HI   = POS_W'(12);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_LEN - 1);

  localparam logic [7:0] CMD_STOP      = 8'h01;
  localparam logic [7:0] CMD_UPDATE    = 8'h02;
  localparam logic [7:0] CMD_DRIVE_REF = 8'h03;
  localparam logic [7:0] CMD_DRIVE_KP  = 8'h04;
  localparam logic [7:0] CMD_DRIVE_KI  = 8'h05;
  localparam logic [7:0] CMD_DRIVE_KD  = 8'h06;
  localparam logic [7:0] CMD_STEER_REF = 8'h07;
  localparam logic [7:0] CMD_STEER_KP  = 8'h08;
  localparam logic [7:0] CMD_STEER_KI  = 8'h09;
  localparam logic [7:0] CMD_STEER_KD  = 8'h0A;
  localparam logic [7:0] CMD_WHEEL_DIA = 8'h0B;
  localparam logic [7:0] CMD_ENC_PPR   = 8'h0C;

  localparam logic [3:0] WIDX_NONE      = 4'd0;
  localparam logic [3:0] WIDX_DRIVE_REF = 4'd1;
  localparam logic [3:0] WIDX_STEER_REF = 4'd2;
  localparam logic [3:0] WIDX_DRIVE_KP  = 4'd3;
  localparam logic [3:0] WIDX_DRIVE_KI  = 4'd4;
  localparam logic [3:0] WIDX_DRIVE_KD  = 4'd5;
  localparam logic [3:0] WIDX_STEER_KP  = 4'd6;
  localparam logic [3:0] WIDX_STEER_KI  = 4'd7;
  localparam logic [3:0] WIDX_STEER_KD  = 4'd8;
  localparam logic [3:0] WIDX_WHEEL_DIA = 4'd9;
  localparam logic [3:0] WIDX_ENC_PPR   = 4'd10;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PAD_ERR = 2'd1,
    ST_UNK_CMD = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        vehicle_stopped;
    logic [31:0] heading_bits;
  } in_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [3:0]  written_index;
    logic [31:0] written_value;
    logic        update_request;
    logic [31:0] drive_ref_out;
    logic [31:0] steer_ref_out;
    logic        halted;
  } out_t;

  // assembled frame, valid on the last byte
  typedef struct packed {
    logic        last;
    logic        pad_ok;
    logic [7:0]  cmd;
    logic [31:0] value;
  } frame_t;

endpackage

### hdl/padded_command_frame_decoder_top.sv
// Top level of the padded command frame decoder.
// A frame's result word is registered and is valid in the cycle after its 17th byte is taken.
// Throughput: one byte per cycle; one result word per 17 bytes.
// The byte path stalls only while a finished result word waits at the output.
// Bytes taken while halted are dropped and produce no word.
// Reset (rst_n low, synchronous) clears position, references and halt state.
module padded_command_frame_decoder_top
  import pcfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  frame_t frame;
  logic   halted;
  logic   take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready && !halted;

  pcfd_collect u_collect (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_data.rx_byte),
    .frame   (frame)
  );

  pcfd_decode u_decode (
    .clk             (clk),
    .rst_n           (rst_n),
    .frame           (frame),
    .vehicle_stopped (in_data.vehicle_stopped),
    .heading_bits    (in_data.heading_bits),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .halted          (halted)
  );

endmodule

### hdl/pcfd_collect.sv
// Byte position tracking, padding check and command/value capture.
module pcfd_collect
  import pcfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output frame_t     frame
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             pad_ok_r, pad_ok_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [31:0]      val_r, val_nxt;
  logic             is_pad;
  logic             is_val;
  logic [1:0]       lane_off;
  logic             byte_pad_ok;

  assign is_val      = (pos_r >= POS_VAL_LO) && (pos_r <= POS_VAL_HI);
  assign is_pad      = !is_val && (pos_r != POS_CMD);
  assign lane_off    = 2'(pos_r - POS_VAL_LO);
  assign byte_pad_ok = !is_pad || (rx_byte == PAD_BYTE);

  always_comb begin
    pos_nxt    = pos_r;
    pad_ok_nxt = pad_ok_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    if (take) begin
      if (pos_r == POS_LAST) begin
        pos_nxt    = '0;
        pad_ok_nxt = 1'b1;
        cmd_nxt    = '0;
        val_nxt    = '0;
      end else begin
        pos_nxt    = pos_r + POS_W'(1);
        pad_ok_nxt = pad_ok_r && byte_pad_ok;
        if (pos_r == POS_CMD) begin
          cmd_nxt = rx_byte;
        end
        if (is_val) begin
          case (lane_off)
            2'd0:    val_nxt[7:0]   = rx_byte;
            2'd1:    val_nxt[15:8]  = rx_byte;
            2'd2:    val_nxt[23:16] = rx_byte;
            default: val_nxt[31:24] = rx_byte;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      pad_ok_r <= 1'b1;
      cmd_r    <= '0;
      val_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      pad_ok_r <= pad_ok_nxt;
      cmd_r    <= cmd_nxt;
      val_r    <= val_nxt;
    end
  end

  // last byte is always a pad position
  assign frame.last   = take && (pos_r == POS_LAST);
  assign frame.pad_ok = pad_ok_r && byte_pad_ok;
  assign frame.cmd    = cmd_r;
  assign frame.value  = val_r;

endmodule

### hdl/pcfd_decode.sv
// Command decode, reference and halt state, and the result register.
module pcfd_decode
  import pcfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  frame_t      frame,
  input  logic        vehicle_stopped,
  input  logic [31:0] heading_bits,
  input  logic        out_ready,
  output logic        out_valid,
  output out_t        out_data,
  output logic        halted
);

  logic        halted_r, halted_nxt;
  logic [31:0] drive_r, drive_nxt;
  logic [31:0] steer_r, steer_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;
  status_t     status;
  logic [3:0]  widx;
  logic [3:0]  slot_idx;
  logic        gated;
  logic        upd;
  logic        fire;

  assign fire = frame.last && !halted_r;

  always_comb begin
    status   = ST_OK;
    widx     = WIDX_NONE;
    slot_idx = WIDX_NONE;
    gated    = 1'b0;
    upd      = 1'b0;
    if (!frame.pad_ok) begin
      status = ST_PAD_ERR;
    end else begin
      unique case (frame.cmd)
        CMD_STOP:      upd = 1'b1;
        CMD_UPDATE:    upd = 1'b1;
        CMD_DRIVE_REF: widx = WIDX_DRIVE_REF;
        CMD_STEER_REF: widx = WIDX_STEER_REF;
        CMD_DRIVE_KP:  begin gated = 1'b1; slot_idx = WIDX_DRIVE_KP;  end
        CMD_DRIVE_KI:  begin gated = 1'b1; slot_idx = WIDX_DRIVE_KI;  end
        CMD_DRIVE_KD:  begin gated = 1'b1; slot_idx = WIDX_DRIVE_KD;  end
        CMD_STEER_KP:  begin gated = 1'b1; slot_idx = WIDX_STEER_KP;  end
        CMD_STEER_KI:  begin gated = 1'b1; slot_idx = WIDX_STEER_KI;  end
        CMD_STEER_KD:  begin gated = 1'b1; slot_idx = WIDX_STEER_KD;  end
        CMD_WHEEL_DIA: begin gated = 1'b1; slot_idx = WIDX_WHEEL_DIA; end
        CMD_ENC_PPR:   begin gated = 1'b1; slot_idx = WIDX_ENC_PPR;   end
        default:       status = ST_UNK_CMD;
      endcase
      if (gated && vehicle_stopped) begin
        widx = slot_idx;
      end
    end
  end

  always_comb begin
    halted_nxt    = halted_r;
    drive_nxt     = drive_r;
    steer_nxt     = steer_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (fire) begin
      if (status != ST_OK || frame.cmd == CMD_STOP) begin
        drive_nxt = '0;
        steer_nxt = heading_bits;
      end else if (widx == WIDX_DRIVE_REF) begin
        drive_nxt = frame.value;
      end else if (widx == WIDX_STEER_REF) begin
        steer_nxt = frame.value;
      end
      halted_nxt             = (status != ST_OK);
      out_valid_nxt          = 1'b1;
      out_nxt.frame_status   = status;
      out_nxt.written_index  = (status != ST_OK) ? WIDX_NONE : widx;
      out_nxt.written_value  = (status != ST_OK || widx == WIDX_NONE) ? '0 : frame.value;
      out_nxt.update_request = upd || (status != ST_OK);
      out_nxt.drive_ref_out  = drive_nxt;
      out_nxt.steer_ref_out  = steer_nxt;
      out_nxt.halted         = halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r    <= 1'b0;
      drive_r     <= '0;
      steer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      halted_r    <= halted_nxt;
      drive_r     <= drive_nxt;
      steer_r     <= steer_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign halted    = halted_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt state cleared without reset");

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.frame_status != ST_OK |-> out_r.halted && out_r.update_request)
    else $error("error word without halt and update");

  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.frame_status != ST_OK |-> out_r.written_index == WIDX_NONE)
    else $error("error word reports a write");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.written_index == WIDX_NONE |-> out_r.written_value == '0)
    else $error("value reported without a write");

  a_refs_match: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_r.drive_ref_out == drive_r && out_r.steer_ref_out == steer_r)
    else $error("result word references differ from held references");

endmodule
